### design/ccsoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccsoc_pkg;

  localparam int CMD_W      = 2;
  localparam int MV_W       = 16;
  localparam int AS_W       = 32;
  localparam int SOC_W      = 14;
  localparam int WHOLE_W    = 7;
  localparam int CAP_W      = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CAP_W-1:0] CAP_RESET = 24'd48600;
  localparam logic [SOC_W-1:0] SOC_FULL  = 14'd10000;
  localparam logic [SOC_W-1:0] SOC_EMPTY = 14'd0;

  // piecewise-linear OCV curve, percent points kept in hundredths
  localparam int TABLE_POINTS = 20;
  localparam int SEG_W        = $clog2(TABLE_POINTS);

  localparam logic [MV_W-1:0] CURVE_MV [TABLE_POINTS] = '{
    16'd2500, 16'd3000, 16'd3200, 16'd3300, 16'd3400,
    16'd3500, 16'd3550, 16'd3600, 16'd3650, 16'd3700,
    16'd3750, 16'd3800, 16'd3850, 16'd3900, 16'd3950,
    16'd4000, 16'd4050, 16'd4100, 16'd4150, 16'd4200};

  localparam logic [SOC_W-1:0] CURVE_SOC [TABLE_POINTS] = '{
    14'd0,    14'd100,  14'd200,  14'd400,  14'd800,
    14'd1400, 14'd2000, 14'd2700, 14'd3500, 14'd4300,
    14'd5200, 14'd6000, 14'd6800, 14'd7400, 14'd8000,
    14'd8500, 14'd9000, 14'd9400, 14'd9700, 14'd10000};

  // datapath widths
  localparam int IPROD_W   = MV_W + SOC_W;
  localparam int PROD_W    = SOC_W + CAP_W;
  localparam int NUM_W     = AS_W + SOC_W + 1;
  localparam int DIV_STEPS = SOC_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DSH_W     = CAP_W + DIV_STEPS - 1;

  localparam logic signed [SOC_W:0] SCALE_S = 15'sd10000;

  // x / 100 == (x * 5243) >> 19 for x < 2^14
  localparam int                 RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] WHOLE_RECIP = 13'd5243;
  localparam int                 WHOLE_SHIFT = 19;
  localparam int                 WPROD_W     = SOC_W + RECIP_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SRESET = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY  = 1'b0,
    REG_DIRECTION = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MUL,
    ST_SUB,
    ST_DIV,
    ST_COMMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic scan_inc;
    logic mul_go;
    logic sub_go;
    logic div_step;
    logic set_const;
    logic commit_div;
    logic commit_base;
    logic commit_sreset;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic mv_le_first;
    logic mv_ge_last;
    logic cap_zero;
    logic held;
    logic seg_hit;
    logic div_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### design/coulomb_count_soc_estimator.sv
// Channel  Signals                                     Direction
// in       in_valid/in_ready, cmd, cell_mv, as_reading  input
// out      out_valid/out_ready, soc/whole/used/flags     output
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data     input, ready always high
//
// One item at a time. Init: a segment scan of up to 19 steps over the voltage
// table, then multiply, subtract and a 14-step restoring divider. Charge
// update: multiply, subtract, same divider. Other commands skip the datapath.
// Reset clears all estimator state; capacity resets to 48600 As.
// A new item is taken while the previous result waits in the output register;
// a stalled output holds the item after that in its final state.
`timescale 1ns / 1ps
`default_nettype none

module coulomb_count_soc_estimator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [ccsoc_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [ccsoc_pkg::MV_W-1:0]          in_cell_mv,
  input  wire logic signed [ccsoc_pkg::AS_W-1:0]   in_as_reading,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ccsoc_pkg::SOC_W-1:0]              out_soc_hundredths,
  output logic [ccsoc_pkg::WHOLE_W-1:0]            out_soc_whole,
  output logic signed [ccsoc_pkg::AS_W-1:0]        out_used_charge_as,
  output logic                                     out_ready_res,
  output logic                                     out_frame_send,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ccsoc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ccsoc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ccsoc_pkg::ctrl_cmd_t cmd;
  ccsoc_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  ccsoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccsoc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_cmd),
    .in_cell_mv         (in_cell_mv),
    .in_as_reading      (in_as_reading),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_soc_hundredths (out_soc_hundredths),
    .out_soc_whole      (out_soc_whole),
    .out_used_charge_as (out_used_charge_as),
    .out_ready_res      (out_ready_res),
    .out_frame_send     (out_frame_send),
    .cmd                (cmd),
    .sts                (sts)
  );

  a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_soc_hundredths <= ccsoc_pkg::SOC_FULL)
    else $error("soc out of range");

  a_whole_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (16'(out_soc_whole) * 16'd100 <= 16'(out_soc_hundredths)) &&
                  (16'(out_soc_hundredths) < 16'(out_soc_whole) * 16'd100 + 16'd100))
    else $error("whole percent mismatch");

  a_send_needs_baseline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_send) |-> (out_soc_whole < 7'd100))
    else $error("frame sent at full charge");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer taken while busy");

endmodule

`default_nettype wire

### design/ccsoc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ccsoc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ccsoc_pkg::ctrl_sts_t  sts,
  output ccsoc_pkg::ctrl_cmd_t       cmd
);

  ccsoc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccsoc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ccsoc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ccsoc_pkg::ST_DECODE;
        end
      end
      ccsoc_pkg::ST_DECODE: begin
        unique case (sts.cmd)
          ccsoc_pkg::CMD_INIT: begin
            if (sts.mv_le_first || sts.mv_ge_last) begin
              state_nxt = ccsoc_pkg::ST_OUT;
            end else begin
              state_nxt = ccsoc_pkg::ST_SCAN;
            end
          end
          ccsoc_pkg::CMD_READ: begin
            if (sts.cap_zero || !sts.held) begin
              state_nxt = ccsoc_pkg::ST_OUT;
            end else begin
              state_nxt = ccsoc_pkg::ST_MUL;
            end
          end
          ccsoc_pkg::CMD_SRESET: state_nxt = ccsoc_pkg::ST_OUT;
          ccsoc_pkg::CMD_NOP:    state_nxt = ccsoc_pkg::ST_OUT;
          default:               state_nxt = ccsoc_pkg::ST_OUT;
        endcase
      end
      ccsoc_pkg::ST_SCAN: begin
        if (sts.seg_hit) begin
          state_nxt = ccsoc_pkg::ST_MUL;
        end
      end
      ccsoc_pkg::ST_MUL: state_nxt = ccsoc_pkg::ST_SUB;
      ccsoc_pkg::ST_SUB: state_nxt = ccsoc_pkg::ST_DIV;
      ccsoc_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ccsoc_pkg::ST_COMMIT;
        end
      end
      ccsoc_pkg::ST_COMMIT: state_nxt = ccsoc_pkg::ST_OUT;
      ccsoc_pkg::ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = ccsoc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ccsoc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ccsoc_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      ccsoc_pkg::ST_DECODE: begin
        unique case (sts.cmd)
          ccsoc_pkg::CMD_INIT:   cmd.set_const     = sts.mv_le_first || sts.mv_ge_last;
          ccsoc_pkg::CMD_READ:   cmd.commit_base   = !sts.cap_zero && !sts.held;
          ccsoc_pkg::CMD_SRESET: cmd.commit_sreset = 1'b1;
          ccsoc_pkg::CMD_NOP:    cmd.commit_sreset = 1'b0;
          default:               cmd.commit_sreset = 1'b0;
        endcase
      end
      ccsoc_pkg::ST_SCAN:   cmd.scan_inc   = !sts.seg_hit;
      ccsoc_pkg::ST_MUL:    cmd.mul_go     = 1'b1;
      ccsoc_pkg::ST_SUB:    cmd.sub_go     = 1'b1;
      ccsoc_pkg::ST_DIV:    cmd.div_step   = 1'b1;
      ccsoc_pkg::ST_COMMIT: cmd.commit_div = 1'b1;
      ccsoc_pkg::ST_OUT:    cmd.out_load   = sts.out_free;
      default:              cmd            = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/ccsoc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ccsoc_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [ccsoc_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [ccsoc_pkg::MV_W-1:0]          in_cell_mv,
  input  wire logic signed [ccsoc_pkg::AS_W-1:0]   in_as_reading,
  input  wire logic                                cfg_valid,
  input  wire logic [ccsoc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ccsoc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ccsoc_pkg::SOC_W-1:0]              out_soc_hundredths,
  output logic [ccsoc_pkg::WHOLE_W-1:0]            out_soc_whole,
  output logic signed [ccsoc_pkg::AS_W-1:0]        out_used_charge_as,
  output logic                                     out_ready_res,
  output logic                                     out_frame_send,
  input  wire ccsoc_pkg::ctrl_cmd_t                cmd,
  output ccsoc_pkg::ctrl_sts_t                     sts
);

  localparam int SOC_W   = ccsoc_pkg::SOC_W;
  localparam int AS_W    = ccsoc_pkg::AS_W;
  localparam int MV_W    = ccsoc_pkg::MV_W;
  localparam int CAP_W   = ccsoc_pkg::CAP_W;
  localparam int SEG_W   = ccsoc_pkg::SEG_W;
  localparam int PROD_W  = ccsoc_pkg::PROD_W;
  localparam int IPROD_W = ccsoc_pkg::IPROD_W;
  localparam int NUM_W   = ccsoc_pkg::NUM_W;
  localparam int DSH_W   = ccsoc_pkg::DSH_W;
  localparam int CNT_W   = ccsoc_pkg::DIV_CNT_W;
  localparam int WPROD_W = ccsoc_pkg::WPROD_W;

  // captured item
  ccsoc_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [MV_W-1:0]               mv_r, mv_nxt;
  logic signed [AS_W-1:0]        rd_r, rd_nxt;

  // config
  logic [CAP_W-1:0]              cap_r, cap_nxt;
  logic                          dir_r, dir_nxt;

  // estimator state
  logic [SOC_W-1:0]              soc_start_r, soc_start_nxt;
  logic [SOC_W-1:0]              soc_cur_r, soc_cur_nxt;
  logic signed [AS_W-1:0]        base_r, base_nxt;
  logic signed [AS_W-1:0]        latest_r, latest_nxt;
  logic                          held_r, held_nxt;
  logic                          init_r, init_nxt;
  logic                          send_r, send_nxt;

  // arithmetic
  logic [SEG_W-1:0]              seg_r, seg_nxt;
  logic [PROD_W-1:0]             p1_r, p1_nxt;
  logic signed [NUM_W-1:0]       p2_r, p2_nxt;
  logic [CAP_W-1:0]              den_r, den_nxt;
  logic [SOC_W-1:0]              pbase_r, pbase_nxt;
  logic [NUM_W-1:0]              rem_r, rem_nxt;
  logic [DSH_W-1:0]              dsh_r, dsh_nxt;
  logic [SOC_W-1:0]              q_r, q_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          neg_r, neg_nxt;
  logic                          sat_r, sat_nxt;

  // result register
  logic                          ov_r, ov_nxt;
  logic [SOC_W-1:0]              o_soc_r, o_soc_nxt;
  logic [ccsoc_pkg::WHOLE_W-1:0] o_whole_r, o_whole_nxt;
  logic signed [AS_W-1:0]        o_used_r, o_used_nxt;
  logic                          o_rdy_r, o_rdy_nxt;
  logic                          o_send_r, o_send_nxt;

  logic [SEG_W-1:0]              seg_hi;
  logic [MV_W-1:0]               seg_lo_mv, seg_hi_mv;
  logic [MV_W-1:0]               dmv;
  logic [SOC_W-1:0]              span100;
  logic [IPROD_W-1:0]            ip_prod;
  logic [PROD_W-1:0]             cp_prod;
  logic signed [AS_W-1:0]        disch_rd, disch_lat;
  logic signed [NUM_W-1:0]       dp_prod;
  logic signed [NUM_W-1:0]       num;
  logic                          ge;
  logic [SOC_W-1:0]              q_clamp;
  logic [SOC_W-1:0]              soc_interp;
  logic [SOC_W-1:0]              soc_edge;
  logic [WPROD_W-1:0]            whole_prod;

  assign seg_hi    = SEG_W'(seg_r + 1'b1);
  assign seg_lo_mv = ccsoc_pkg::CURVE_MV[seg_r];
  assign seg_hi_mv = ccsoc_pkg::CURVE_MV[seg_hi];
  assign dmv       = mv_r - seg_lo_mv;
  assign span100   = ccsoc_pkg::CURVE_SOC[seg_hi] - ccsoc_pkg::CURVE_SOC[seg_r];
  assign ip_prod   = IPROD_W'(dmv) * IPROD_W'(span100);
  assign cp_prod   = PROD_W'(soc_start_r) * PROD_W'(cap_r);

  assign disch_rd  = dir_r ? (rd_r - base_r) : (base_r - rd_r);
  assign disch_lat = dir_r ? (latest_r - base_r) : (base_r - latest_r);
  assign dp_prod   = NUM_W'(disch_rd) * NUM_W'(ccsoc_pkg::SCALE_S);

  assign num = $signed({{(NUM_W-PROD_W){1'b0}}, p1_r}) - p2_r;
  assign ge  = rem_r >= {{(NUM_W-DSH_W){1'b0}}, dsh_r};

  always_comb begin
    priority if (neg_r) begin
      q_clamp = ccsoc_pkg::SOC_EMPTY;
    end else if (sat_r || (q_r > ccsoc_pkg::SOC_FULL)) begin
      q_clamp = ccsoc_pkg::SOC_FULL;
    end else begin
      q_clamp = q_r;
    end
  end

  assign soc_interp = pbase_r + q_r;
  assign soc_edge   = sts.mv_le_first ? ccsoc_pkg::CURVE_SOC[0]
                                      : ccsoc_pkg::CURVE_SOC[ccsoc_pkg::TABLE_POINTS-1];
  assign whole_prod = WPROD_W'(soc_cur_r) * WPROD_W'(ccsoc_pkg::WHOLE_RECIP);

  always_comb begin
    sts.cmd         = cmd_r;
    sts.mv_le_first = mv_r <= ccsoc_pkg::CURVE_MV[0];
    sts.mv_ge_last  = mv_r >= ccsoc_pkg::CURVE_MV[ccsoc_pkg::TABLE_POINTS-1];
    sts.cap_zero    = cap_r == '0;
    sts.held        = held_r;
    sts.seg_hit     = (mv_r >= seg_lo_mv) && (mv_r <= seg_hi_mv);
    sts.div_last    = cnt_r == CNT_W'(ccsoc_pkg::DIV_STEPS - 1);
    sts.out_free    = !ov_r || out_ready;
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    mv_nxt        = mv_r;
    rd_nxt        = rd_r;
    cap_nxt       = cap_r;
    dir_nxt       = dir_r;
    soc_start_nxt = soc_start_r;
    soc_cur_nxt   = soc_cur_r;
    base_nxt      = base_r;
    latest_nxt    = latest_r;
    held_nxt      = held_r;
    init_nxt      = init_r;
    send_nxt      = send_r;
    seg_nxt       = seg_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    den_nxt       = den_r;
    pbase_nxt     = pbase_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    ov_nxt        = ov_r;
    o_soc_nxt     = o_soc_r;
    o_whole_nxt   = o_whole_r;
    o_used_nxt    = o_used_r;
    o_rdy_nxt     = o_rdy_r;
    o_send_nxt    = o_send_r;

    if (cfg_valid) begin
      unique case (ccsoc_pkg::cfg_reg_t'(cfg_index))
        ccsoc_pkg::REG_CAPACITY:  cap_nxt = cfg_data;
        ccsoc_pkg::REG_DIRECTION: dir_nxt = cfg_data[0];
        default:                  cap_nxt = cap_r;
      endcase
    end

    if (cmd.latch_in) begin
      cmd_nxt  = ccsoc_pkg::cmd_t'(in_cmd);
      mv_nxt   = in_cell_mv;
      rd_nxt   = in_as_reading;
      seg_nxt  = '0;
      send_nxt = 1'b0;
    end

    if (cmd.scan_inc) begin
      seg_nxt = seg_hi;
    end

    if (cmd.mul_go) begin
      if (cmd_r == ccsoc_pkg::CMD_INIT) begin
        p1_nxt    = PROD_W'(ip_prod);
        p2_nxt    = '0;
        den_nxt   = CAP_W'(seg_hi_mv - seg_lo_mv);
        pbase_nxt = ccsoc_pkg::CURVE_SOC[seg_r];
      end else begin
        p1_nxt    = cp_prod;
        p2_nxt    = dp_prod;
        den_nxt   = cap_r;
        pbase_nxt = '0;
      end
    end

    if (cmd.sub_go) begin
      neg_nxt = num[NUM_W-1];
      sat_nxt = !num[NUM_W-1] &&
                (NUM_W'(num) >= {{(NUM_W-CAP_W-SOC_W){1'b0}}, den_r, {SOC_W{1'b0}}});
      rem_nxt = num[NUM_W-1] ? '0 : NUM_W'(num);
      dsh_nxt = {den_r, {(DSH_W-CAP_W){1'b0}}};
      q_nxt   = '0;
      cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      if (ge) begin
        rem_nxt = rem_r - {{(NUM_W-DSH_W){1'b0}}, dsh_r};
      end
      q_nxt   = {q_r[SOC_W-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end

    if (cmd.set_const) begin
      soc_start_nxt = soc_edge;
      soc_cur_nxt   = soc_edge;
      held_nxt      = 1'b0;
      base_nxt      = '0;
      latest_nxt    = '0;
      init_nxt      = 1'b1;
    end

    if (cmd.commit_div) begin
      if (cmd_r == ccsoc_pkg::CMD_INIT) begin
        soc_start_nxt = soc_interp;
        soc_cur_nxt   = soc_interp;
        held_nxt      = 1'b0;
        base_nxt      = '0;
        latest_nxt    = '0;
        init_nxt      = 1'b1;
      end else begin
        soc_cur_nxt = q_clamp;
        latest_nxt  = rd_r;
        send_nxt    = q_clamp < ccsoc_pkg::SOC_FULL;
      end
    end

    if (cmd.commit_base) begin
      latest_nxt = rd_r;
      base_nxt   = rd_r;
      held_nxt   = 1'b1;
    end

    if (cmd.commit_sreset) begin
      soc_start_nxt = soc_cur_r;
      held_nxt      = 1'b0;
      base_nxt      = '0;
    end

    priority if (cmd.out_load) begin
      ov_nxt      = 1'b1;
      o_soc_nxt   = soc_cur_r;
      o_whole_nxt = whole_prod[ccsoc_pkg::WHOLE_SHIFT +: ccsoc_pkg::WHOLE_W];
      o_used_nxt  = held_r ? disch_lat : '0;
      o_rdy_nxt   = init_r && held_r;
      o_send_nxt  = send_r;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= ccsoc_pkg::CAP_RESET;
      dir_r       <= 1'b0;
      soc_start_r <= '0;
      soc_cur_r   <= '0;
      base_r      <= '0;
      latest_r    <= '0;
      held_r      <= 1'b0;
      init_r      <= 1'b0;
      send_r      <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      dir_r       <= dir_nxt;
      soc_start_r <= soc_start_nxt;
      soc_cur_r   <= soc_cur_nxt;
      base_r      <= base_nxt;
      latest_r    <= latest_nxt;
      held_r      <= held_nxt;
      init_r      <= init_nxt;
      send_r      <= send_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    mv_r      <= mv_nxt;
    rd_r      <= rd_nxt;
    seg_r     <= seg_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    den_r     <= den_nxt;
    pbase_r   <= pbase_nxt;
    rem_r     <= rem_nxt;
    dsh_r     <= dsh_nxt;
    q_r       <= q_nxt;
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    sat_r     <= sat_nxt;
    o_soc_r   <= o_soc_nxt;
    o_whole_r <= o_whole_nxt;
    o_used_r  <= o_used_nxt;
    o_rdy_r   <= o_rdy_nxt;
    o_send_r  <= o_send_nxt;
  end

  assign out_valid          = ov_r;
  assign out_soc_hundredths = o_soc_r;
  assign out_soc_whole      = o_whole_r;
  assign out_used_charge_as = o_used_r;
  assign out_ready_res      = o_rdy_r;
  assign out_frame_send     = o_send_r;

endmodule

`default_nettype wire

### test/tb_coulomb_count_soc_estimator.sv
`timescale 1ns / 1ps

module tb_coulomb_count_soc_estimator;
  import ccsoc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int OCV_POINTS  = 20;

  localparam int OCV_MV [OCV_POINTS] = '{
    2500, 3000, 3200, 3300, 3400, 3500, 3550, 3600, 3650, 3700,
    3750, 3800, 3850, 3900, 3950, 4000, 4050, 4100, 4150, 4200};
  localparam int OCV_PCT [OCV_POINTS] = '{
    0, 1, 2, 4, 8, 14, 20, 27, 35, 43,
    52, 60, 68, 74, 80, 85, 90, 94, 97, 100};

  typedef struct packed {
    logic [SOC_W-1:0]          soc;
    logic [WHOLE_W-1:0]        whole;
    logic signed [AS_W-1:0]    used;
    logic                      ready_res;
    logic                      frame;
  } soc_result_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [MV_W-1:0]     mv;
    logic [AS_W-1:0]     reading;
    logic                typed;
    soc_result_t         res;
  } soc_row_t;

  localparam soc_result_t NO_RES     = '0;
  localparam soc_result_t EMPTY_RES  = '{14'd0, 7'd0, 32'sd0, 1'b0, 1'b0};
  localparam soc_result_t FULL_RES   = '{14'd10000, 7'd100, 32'sd0, 1'b0, 1'b0};
  localparam soc_result_t FULL_READY = '{14'd10000, 7'd100, 32'sd0, 1'b1, 1'b0};

  localparam int DIR_ROWS = 24;
  localparam soc_row_t DIR_TABLE [DIR_ROWS] = '{
    '{CMD_READ,   16'hFFFF, 32'd1000,     1'b1, EMPTY_RES},
    '{CMD_NOP,    16'h0000, 32'hFFFFFFFF, 1'b1, EMPTY_RES},
    '{CMD_INIT,   16'd0,    32'h00000000, 1'b1, EMPTY_RES},
    '{CMD_INIT,   16'd2500, 32'h12345678, 1'b1, EMPTY_RES},
    '{CMD_INIT,   16'hFFFF, 32'hFFFFFFFF, 1'b1, FULL_RES},
    '{CMD_INIT,   16'd4200, 32'h80000000, 1'b1, FULL_RES},
    '{CMD_READ,   16'h0000, 32'h7FFFFFFF, 1'b1, FULL_READY},
    '{CMD_READ,   16'hFFFF, 32'h7FFFFFFF, 1'b1, FULL_READY},
    '{CMD_READ,   16'h0000, 32'h80000000, 1'b0, NO_RES},
    '{CMD_READ,   16'h0000, 32'h7FFF4227, 1'b0, NO_RES},
    '{CMD_READ,   16'h0000, 32'd1000,     1'b0, NO_RES},
    '{CMD_SRESET, 16'hFFFF, 32'hFFFFFFFF, 1'b0, NO_RES},
    '{CMD_NOP,    16'h0000, 32'h00000000, 1'b0, NO_RES},
    '{CMD_INIT,   16'd3623, 32'h00000000, 1'b0, NO_RES},
    '{CMD_INIT,   16'd3000, 32'h00000000, 1'b0, NO_RES},
    '{CMD_INIT,   16'd2501, 32'h00000000, 1'b0, NO_RES},
    '{CMD_INIT,   16'd4199, 32'h00000000, 1'b0, NO_RES},
    '{CMD_READ,   16'h0000, 32'd0,        1'b0, NO_RES},
    '{CMD_READ,   16'h0000, 32'd100,      1'b0, NO_RES},
    '{CMD_READ,   16'h0000, 32'hFFFFFF9C, 1'b0, NO_RES},
    '{CMD_SRESET, 16'h0000, 32'h00000000, 1'b0, NO_RES},
    '{CMD_READ,   16'h0000, 32'd5,        1'b0, NO_RES},
    '{CMD_READ,   16'h0000, 32'h80000000, 1'b0, NO_RES},
    '{CMD_NOP,    16'hFFFF, 32'h00000000, 1'b0, NO_RES}};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_W-1:0]       in_cmd = '0;
  logic [MV_W-1:0]        in_cell_mv = '0;
  logic signed [AS_W-1:0] in_as_reading = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SOC_W-1:0]       out_soc_hundredths;
  logic [WHOLE_W-1:0]     out_soc_whole;
  logic signed [AS_W-1:0] out_used_charge_as;
  logic                   out_ready_res;
  logic                   out_frame_send;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  coulomb_count_soc_estimator uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_cell_mv         (in_cell_mv),
    .in_as_reading      (in_as_reading),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_soc_hundredths (out_soc_hundredths),
    .out_soc_whole      (out_soc_whole),
    .out_used_charge_as (out_used_charge_as),
    .out_ready_res      (out_ready_res),
    .out_frame_send     (out_frame_send),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // estimator shadow state
  logic [SOC_W-1:0] est_start;
  logic [SOC_W-1:0] est_current;
  logic [AS_W-1:0]  est_base;
  logic [AS_W-1:0]  est_latest;
  logic             est_held;
  logic             est_init;
  logic [CAP_W-1:0] est_cap;
  logic             est_dir;

  soc_result_t soc_expected [$];
  soc_result_t soc_want;
  logic [AS_W-1:0] sensor_count;
  int  mismatches = 0;
  int  cycles = 0;
  int  hold_left = 0;
  bit  hold_request = 1'b0;
  bit  jitter_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [SOC_W-1:0] ocv_to_soc(input logic [MV_W-1:0] mv);
    int m;
    int i;
    m = int'(mv);
    if (m <= OCV_MV[0]) return SOC_W'(OCV_PCT[0] * 100);
    if (m >= OCV_MV[OCV_POINTS-1]) return SOC_W'(OCV_PCT[OCV_POINTS-1] * 100);
    for (i = 0; i < OCV_POINTS - 1; i++) begin
      if (m >= OCV_MV[i] && m <= OCV_MV[i+1]) begin
        return SOC_W'(OCV_PCT[i] * 100 +
                      ((m - OCV_MV[i]) * (OCV_PCT[i+1] - OCV_PCT[i]) * 100) /
                      (OCV_MV[i+1] - OCV_MV[i]));
      end
    end
    return '0;
  endfunction

  function automatic logic signed [AS_W-1:0] discharged_from(input logic [AS_W-1:0] rd);
    return est_dir ? rd - est_base : est_base - rd;
  endfunction

  function automatic soc_result_t predict_soc(input cmd_t c, input logic [MV_W-1:0] mv,
                                              input logic [AS_W-1:0] rd);
    soc_result_t r;
    longint num;
    longint q;
    logic send;
    send = 1'b0;
    case (c)
      CMD_INIT: begin
        est_start   = ocv_to_soc(mv);
        est_current = est_start;
        est_held    = 1'b0;
        est_base    = '0;
        est_latest  = '0;
        est_init    = 1'b1;
      end
      CMD_READ: begin
        if (est_cap != 0) begin
          est_latest = rd;
          if (!est_held) begin
            est_base = rd;
            est_held = 1'b1;
          end else begin
            num = longint'(est_start) * longint'(est_cap)
                  - longint'(discharged_from(rd)) * 10000;
            q = (num < 0) ? 0 : num / longint'(est_cap);
            if (q > 10000) q = 10000;
            est_current = q[SOC_W-1:0];
            send = (est_current / 100) < 100;
          end
        end
      end
      CMD_SRESET: begin
        est_start = est_current;
        est_held  = 1'b0;
        est_base  = '0;
      end
      default: ;
    endcase
    r.soc       = est_current;
    r.whole     = WHOLE_W'(est_current / 100);
    r.used      = est_held ? discharged_from(est_latest) : '0;
    r.ready_res = est_init && est_held;
    r.frame     = send;
    return r;
  endfunction

  task automatic send_item(input cmd_t c, input logic [MV_W-1:0] mv,
                           input logic [AS_W-1:0] rd, input logic typed,
                           input soc_result_t typed_res);
    soc_result_t predicted;
    @(negedge clk);
    while (jitter_on && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_cell_mv    <= mv;
    in_as_reading <= rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_soc(c, mv, rd);
    soc_expected.push_back(typed ? typed_res : predicted);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_CAPACITY) est_cap = val;
    else est_dir = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly a plausible sensor trace, with jumps, resets and re-inits mixed in
  task automatic send_random_item();
    int pick;
    int span;
    int delta;
    cmd_t c;
    logic [MV_W-1:0] mv;
    logic [AS_W-1:0] rd;
    pick = $urandom_range(0, 99);
    mv   = MV_W'($urandom());
    rd   = $urandom();
    if (pick < 6) begin
      c = CMD_INIT;
      if ($urandom_range(0, 9) < 7) mv = MV_W'($urandom_range(2400, 4300));
    end else if (pick < 10) begin
      c = CMD_SRESET;
    end else if (pick < 13) begin
      c = CMD_NOP;
    end else if (pick < 18) begin
      c = CMD_READ;
      sensor_count = rd;
    end else begin
      c = CMD_READ;
      span  = int'(est_cap) / 20 + 2;
      delta = int'($urandom_range(0, span)) - span / 4;
      sensor_count = est_dir ? sensor_count + delta : sensor_count - delta;
      rd = sensor_count;
    end
    send_item(c, mv, rd, 1'b0, NO_RES);
  endtask

  task automatic check_field(input string name, input logic [AS_W-1:0] want,
                             input logic [AS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (soc_expected.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        soc_want = soc_expected.pop_front();
        check_field("soc_hundredths", AS_W'(soc_want.soc), AS_W'(out_soc_hundredths));
        check_field("soc_whole", AS_W'(soc_want.whole), AS_W'(out_soc_whole));
        check_field("used_charge_as", soc_want.used, out_used_charge_as);
        check_field("ready_res", AS_W'(soc_want.ready_res), AS_W'(out_ready_res));
        check_field("frame_send", AS_W'(soc_want.frame), AS_W'(out_frame_send));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(jitter_on && $urandom_range(0, 99) < 7);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0]      cap;
    logic [CFG_DATA_W-1:0] dir_word;
    logic                  dir_bit;
    int                    count;
    est_start    = '0;
    est_current  = '0;
    est_base     = '0;
    est_latest   = '0;
    est_held     = 1'b0;
    est_init     = 1'b0;
    est_cap      = CAP_RESET;
    est_dir      = 1'b0;
    sensor_count = $urandom();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(DIR_TABLE[r].cmd, DIR_TABLE[r].mv, DIR_TABLE[r].reading,
                DIR_TABLE[r].typed, DIR_TABLE[r].res);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    for (int ph = 0; ph < 9; ph++) begin
      while (soc_expected.size() != 0) @(posedge clk);
      jitter_on = (ph != 4);
      if (ph == 0 || ph == 6) hold_request = 1'b1;
      count = 150;
      case (ph)
        0: begin cap = CAP_RESET;     dir_bit = 1'b1; end
        1: begin cap = 24'd1;         dir_bit = 1'b0; end
        2: begin cap = 24'hFFFFFF;    dir_bit = 1'b1; end
        3: begin cap = 24'd0;         dir_bit = 1'b0; count = 50; end
        4: begin cap = CAP_W'($urandom_range(1, 24'hFFFFFF)); dir_bit = 1'($urandom()); end
        5: begin cap = 24'd3600;      dir_bit = 1'b0; end
        6: begin cap = CAP_RESET;     dir_bit = 1'b0; end
        7: begin cap = CAP_W'($urandom_range(1, 1000)); dir_bit = 1'b1; end
        default: begin cap = CAP_RESET; dir_bit = 1'b0; end
      endcase
      dir_word    = CFG_DATA_W'($urandom());
      dir_word[0] = dir_bit;
      write_reg(REG_CAPACITY, cap);
      write_reg(REG_DIRECTION, dir_word);
      send_item(CMD_INIT, MV_W'($urandom_range(2400, 4300)), $urandom(), 1'b0, NO_RES);
      repeat (count) send_random_item();
      @(negedge clk);
      in_valid <= 1'b0;
    end

    while (soc_expected.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && soc_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/ccsoc_pkg.sv
design/ccsoc_ctrl.sv
design/ccsoc_dp.sv
design/coulomb_count_soc_estimator.sv
test/tb_coulomb_count_soc_estimator.sv
